/* src/refcounted_inode_cache_assert.svh */
// Assertion macros used by the RTL of the inode cache datapath.
`ifndef REFCOUNTED_INODE_CACHE_ASSERT_SVH
`define REFCOUNTED_INODE_CACHE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RIC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("inode cache assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RIC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("inode cache assertion failed");

`endif

/* src/ric_pkg.sv */
package ric_pkg;

    localparam int INO_W    = 16;
    localparam int REFS_W   = 16;
    localparam int SIDX_W   = 6;
    localparam int CNT_W    = 17;
    localparam int STATUS_W = 4;

    localparam logic [CNT_W-1:0]  COUNT_RESET = 17'h10000;
    localparam logic [REFS_W-1:0] REFS_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CREATE  = 2'd2,
        OP_DIRTY   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 4'd0,
        ST_MISS     = 4'd1,
        ST_FULL     = 4'd2,
        ST_BADNUM   = 4'd3,
        ST_STILL    = 4'd4,
        ST_CLEAN    = 4'd5,
        ST_WBACK    = 4'd6,
        ST_DESTROY  = 4'd7,
        ST_CREATED  = 4'd8,
        ST_CFAIL    = 4'd9,
        ST_DIRTIED  = 4'd10,
        ST_IGNORED  = 4'd11
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE
    } t_state;

    // One entry of the slot table.
    typedef struct packed {
        logic [INO_W-1:0]  inode;
        logic [REFS_W-1:0] refs;
        logic              dirty;
    } t_slot;

    // Controller to datapath.
    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    rd_slot;
        logic    commit;
        t_status status;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_op  op;
        logic bad;
        logic slot_ok;
        logic scan_done;
        logic hit;
        logic free;
        logic refs_gt1;
        logic dirty;
        logic links_zero;
        logic out_free;
    } t_stat;

endpackage

/* src/ric_ctrl.sv */
module ric_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ric_pkg::t_stat i_stat,
    output ric_pkg::t_cmd  o_cmd
);

    ric_pkg::t_state  r_state;
    ric_pkg::t_state  n_state;
    ric_pkg::t_status w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ric_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result code from the flags gathered by the datapath.
    always_comb begin
        w_result = ric_pkg::ST_IGNORED;
        unique case (i_stat.op)
            ric_pkg::OP_GET: begin
                if (i_stat.bad) begin
                    w_result = ric_pkg::ST_BADNUM;
                end else if (i_stat.hit) begin
                    w_result = ric_pkg::ST_HIT;
                end else if (i_stat.free) begin
                    w_result = ric_pkg::ST_MISS;
                end else begin
                    w_result = ric_pkg::ST_FULL;
                end
            end
            ric_pkg::OP_CREATE: begin
                w_result = i_stat.free ? ric_pkg::ST_CREATED : ric_pkg::ST_CFAIL;
            end
            ric_pkg::OP_RELEASE, ric_pkg::OP_DIRTY: begin
                priority if (!i_stat.slot_ok) begin
                    w_result = ric_pkg::ST_IGNORED;
                end else if (i_stat.op == ric_pkg::OP_DIRTY) begin
                    w_result = ric_pkg::ST_DIRTIED;
                end else if (i_stat.refs_gt1) begin
                    w_result = ric_pkg::ST_STILL;
                end else if (i_stat.links_zero) begin
                    w_result = ric_pkg::ST_DESTROY;
                end else if (i_stat.dirty) begin
                    w_result = ric_pkg::ST_WBACK;
                end else begin
                    w_result = ric_pkg::ST_CLEAN;
                end
            end
        endcase
    end

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.scan_start = 1'b0;
        o_cmd.rd_slot    = 1'b0;
        o_cmd.commit     = 1'b0;
        o_cmd.status     = w_result;
        unique case (r_state)
            ric_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ric_pkg::S_DISPATCH;
                end
            end
            ric_pkg::S_DISPATCH: begin
                unique case (i_stat.op)
                    ric_pkg::OP_GET: begin
                        if (i_stat.bad) begin
                            n_state = ric_pkg::S_DECIDE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ric_pkg::S_SCAN;
                        end
                    end
                    ric_pkg::OP_CREATE: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = ric_pkg::S_SCAN;
                    end
                    ric_pkg::OP_RELEASE, ric_pkg::OP_DIRTY: begin
                        o_cmd.rd_slot = i_stat.slot_ok;
                        n_state       = ric_pkg::S_DECIDE;
                    end
                endcase
            end
            ric_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ric_pkg::S_DECIDE;
                end
            end
            ric_pkg::S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ric_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

/* src/ric_dp.sv */
module ric_dp #(
    parameter int SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ric_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  logic [1:0]                       i_in_op,
    input  logic [ric_pkg::INO_W-1:0]        i_in_ino,
    input  logic [ric_pkg::SIDX_W-1:0]       i_in_sidx,
    input  logic                             i_in_lz,
    input  ric_pkg::t_cmd                    i_cmd,
    output ric_pkg::t_stat                   o_stat,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ric_pkg::STATUS_W-1:0]     o_out_status,
    output logic [ric_pkg::SIDX_W-1:0]       o_out_slot,
    output logic [ric_pkg::INO_W-1:0]        o_out_ino,
    output logic [ric_pkg::REFS_W-1:0]       o_out_refs
);

    `include "refcounted_inode_cache_assert.svh"

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

    // Latched item and configuration.
    ric_pkg::t_op                   r_op;
    logic [ric_pkg::INO_W-1:0]      r_ino;
    logic [ric_pkg::SIDX_W-1:0]     r_sidx;
    logic                           r_lz;
    logic [ric_pkg::CNT_W-1:0]      r_count;

    // Slot table.
    logic [SLOTS-1:0]               r_valid;
    ric_pkg::t_slot                 r_mem [SLOTS];
    ric_pkg::t_slot                 r_rd;

    // Scan.
    logic [SLOT_W-1:0]              r_scan;
    logic                           r_scan_on;
    logic [SLOT_W-1:0]              r_chk_idx;
    logic                           r_chk_on;
    logic                           r_hit;
    logic [SLOT_W-1:0]              r_hit_idx;
    logic [ric_pkg::REFS_W-1:0]     r_hit_refs;
    logic                           r_hit_dirty;
    logic                           r_free;
    logic [SLOT_W-1:0]              r_free_idx;

    // Output register.
    logic                           r_out_valid;
    ric_pkg::t_status               r_out_status;
    logic [ric_pkg::SIDX_W-1:0]     r_out_slot;
    logic [ric_pkg::INO_W-1:0]      r_out_ino;
    logic [ric_pkg::REFS_W-1:0]     r_out_refs;
    ric_pkg::t_status               n_out_status;
    logic [ric_pkg::SIDX_W-1:0]     n_out_slot;
    logic [ric_pkg::INO_W-1:0]      n_out_ino;
    logic [ric_pkg::REFS_W-1:0]     n_out_refs;

    logic [SLOT_W-1:0]              w_sidx_slot;
    logic                           w_slot_ok;
    logic                           w_bad;
    logic [SLOT_W-1:0]              w_rd_addr;
    logic                           w_rd_en;
    logic                           w_scan_done;
    logic [ric_pkg::REFS_W-1:0]     w_hit_next;
    logic                           w_wr_en;
    logic [SLOT_W-1:0]              w_wr_addr;
    ric_pkg::t_slot                 w_wr_data;
    logic                           w_set_valid;
    logic                           w_clr_valid;

    assign w_sidx_slot = r_sidx[SLOT_W-1:0];
    assign w_slot_ok   = ({1'b0, r_sidx} < 7'(SLOTS)) && r_valid[w_sidx_slot];
    assign w_bad       = {1'b0, r_ino} >= r_count;
    assign w_rd_addr   = r_scan_on ? r_scan : w_sidx_slot;
    assign w_rd_en     = r_scan_on || i_cmd.rd_slot;
    assign w_scan_done = r_chk_on && (r_chk_idx == LAST);
    assign w_hit_next  = (r_hit_refs == ric_pkg::REFS_MAX) ? r_hit_refs
                                                           : r_hit_refs + 16'd1;

    assign o_stat.op         = r_op;
    assign o_stat.bad        = w_bad;
    assign o_stat.slot_ok    = w_slot_ok;
    assign o_stat.scan_done  = w_scan_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.free       = r_free;
    assign o_stat.refs_gt1   = r_rd.refs > 16'd1;
    assign o_stat.dirty      = r_rd.dirty;
    assign o_stat.links_zero = r_lz;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    // Table update and result fields for the chosen result code.
    always_comb begin
        w_wr_en      = 1'b0;
        w_wr_addr    = w_sidx_slot;
        w_wr_data    = r_rd;
        w_set_valid  = 1'b0;
        w_clr_valid  = 1'b0;
        n_out_status = i_cmd.status;
        n_out_slot   = '0;
        n_out_ino    = r_ino;
        n_out_refs   = '0;
        unique case (i_cmd.status)
            ric_pkg::ST_HIT: begin
                w_wr_en         = i_cmd.commit;
                w_wr_addr       = r_hit_idx;
                w_wr_data.inode = r_ino;
                w_wr_data.refs  = w_hit_next;
                w_wr_data.dirty = r_hit_dirty;
                n_out_slot      = ric_pkg::SIDX_W'(r_hit_idx);
                n_out_refs      = w_hit_next;
            end
            ric_pkg::ST_MISS, ric_pkg::ST_CREATED: begin
                w_wr_en         = i_cmd.commit;
                w_set_valid     = i_cmd.commit;
                w_wr_addr       = r_free_idx;
                w_wr_data.inode = r_ino;
                w_wr_data.refs  = 16'd1;
                w_wr_data.dirty = (i_cmd.status == ric_pkg::ST_CREATED);
                n_out_slot      = ric_pkg::SIDX_W'(r_free_idx);
                n_out_refs      = 16'd1;
            end
            ric_pkg::ST_STILL: begin
                w_wr_en        = i_cmd.commit;
                w_wr_data.refs = r_rd.refs - 16'd1;
                n_out_slot     = r_sidx;
                n_out_ino      = r_rd.inode;
                n_out_refs     = r_rd.refs - 16'd1;
            end
            ric_pkg::ST_CLEAN, ric_pkg::ST_WBACK, ric_pkg::ST_DESTROY: begin
                w_clr_valid = i_cmd.commit;
                n_out_slot  = r_sidx;
                n_out_ino   = r_rd.inode;
            end
            ric_pkg::ST_DIRTIED: begin
                w_wr_en         = i_cmd.commit;
                w_wr_data.dirty = 1'b1;
                n_out_slot      = r_sidx;
                n_out_ino       = r_rd.inode;
                n_out_refs      = r_rd.refs;
            end
            ric_pkg::ST_IGNORED: begin
                n_out_slot = r_sidx;
                n_out_ino  = '0;
            end
            default: begin
                // Full, bad number and failed create give the number back.
                n_out_slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= ric_pkg::COUNT_RESET;
            r_valid     <= '0;
            r_scan_on   <= 1'b0;
            r_chk_on    <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_set_valid) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (w_clr_valid) begin
                r_valid[w_sidx_slot] <= 1'b0;
            end
            r_chk_on <= r_scan_on;
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
            end else if (r_scan_on && (r_scan == LAST)) begin
                r_scan_on <= 1'b0;
            end
            if (r_chk_on) begin
                if (r_valid[r_chk_idx] && (r_rd.inode == r_ino) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (!r_valid[r_chk_idx] && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= ric_pkg::t_op'(i_in_op);
            r_ino  <= i_in_ino;
            r_sidx <= i_in_sidx;
            r_lz   <= i_in_lz;
        end
        if (i_cmd.scan_start) begin
            r_scan <= '0;
        end else if (r_scan_on) begin
            r_scan <= r_scan + SLOT_W'(1);
        end
        r_chk_idx <= r_scan;
        if (r_chk_on) begin
            if (r_valid[r_chk_idx] && (r_rd.inode == r_ino) && !r_hit) begin
                r_hit_idx   <= r_chk_idx;
                r_hit_refs  <= r_rd.refs;
                r_hit_dirty <= r_rd.dirty;
            end
            if (!r_valid[r_chk_idx] && !r_free) begin
                r_free_idx <= r_chk_idx;
            end
        end
        if (i_cmd.commit) begin
            r_out_status <= n_out_status;
            r_out_slot   <= n_out_slot;
            r_out_ino    <= n_out_ino;
            r_out_refs   <= n_out_refs;
        end
    end

    // Slot table memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;
    assign o_out_ino    = r_out_ino;
    assign o_out_refs   = r_out_refs;

    `RIC_ASSERT_IMP(a_claim_free_slot, i_clk, i_rst_n, w_set_valid, !r_valid[w_wr_addr])
    `RIC_ASSERT_NXT(a_free_clears_slot, i_clk, i_rst_n, w_clr_valid, !r_valid[$past(w_sidx_slot)])
    `RIC_ASSERT_IMP(a_no_commit_in_scan, i_clk, i_rst_n, i_cmd.commit, !r_scan_on && !r_chk_on)

endmodule

/* src/refcounted_inode_cache.sv */
// Reference-counted inode cache. A table of SLOTS entries holds inode numbers,
// each with a reference count and a dirty mark. Every input item gives exactly
// one result item. Get (op 0) rejects numbers not below inode_count, raises
// the count of a hit (saturating at 65535) or claims the lowest free slot with
// count one and reports a miss for the caller to fetch; a full table fails.
// Create (op 2) claims the lowest free slot, dirty, or fails so the number can
// be returned. Release (op 1) lowers a count and at zero frees the slot,
// reporting clean, write-back or destroy (links_zero set); mark dirty (op 3)
// sets the flag; both ignore a free or out-of-range slot. The block handles one
// item at a time. Get and create walk the whole table through its single read
// port, one slot a cycle; release and mark dirty read at most one slot, and a
// get of a bad number reads none. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken; only
// when an earlier result is still held there does the decision cycle stretch
// until it is taken. inode_count is written through i_cfg_we and i_cfg_wdata
// and resets to 65536; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module refcounted_inode_cache #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: inode_count.
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    // Request items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // inode_number[15:0], slot_index[21:16],
                                          // links_zero[22], zero[23]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // Result items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // slot_out[5:0], inode_out[21:6],
                                          // refs_out[37:22], zero[39:38]
    output logic [3:0]  o_m_axis_tuser    // status[3:0]
);

    ric_pkg::t_cmd  w_cmd;
    ric_pkg::t_stat w_stat;

    logic [ric_pkg::STATUS_W-1:0] w_out_status;
    logic [ric_pkg::SIDX_W-1:0]   w_out_slot;
    logic [ric_pkg::INO_W-1:0]    w_out_ino;
    logic [ric_pkg::REFS_W-1:0]   w_out_refs;

    // The controller sequences each item: latch, dispatch, table scan, a single
    // slot read or neither, then the decision that commits the result.
    ric_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the slot table, the scan pipeline and the result
    // register.
    ric_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_op      (i_s_axis_tuser),
        .i_in_ino     (i_s_axis_tdata[15:0]),
        .i_in_sidx    (i_s_axis_tdata[21:16]),
        .i_in_lz      (i_s_axis_tdata[22]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_status (w_out_status),
        .o_out_slot   (w_out_slot),
        .o_out_ino    (w_out_ino),
        .o_out_refs   (w_out_refs)
    );

    assign o_m_axis_tuser = w_out_status;
    assign o_m_axis_tdata = {2'b00, w_out_refs, w_out_ino, w_out_slot};

endmodule
